// ===== rtl/rmq_pkg.sv =====
// Shared constants and types for the rotation-matrix-to-quaternion block.
`default_nettype none

package rmq_pkg;

    localparam int FIELD_W    = 16;
    localparam int IN_FIELDS  = 9;
    localparam int IN_W       = FIELD_W * IN_FIELDS;
    localparam int OUT_W      = 4 * FIELD_W;
    localparam int NORM_TOP   = 24;
    localparam int SQRT_EXTRA = 6;
    localparam int SQ_W       = 2 * NORM_TOP;
    localparam int SUM_W      = SQ_W + 2;
    localparam int SQ_IN_W    = SUM_W + 2 * SQRT_EXTRA;
    localparam int ROOT_W     = SQ_IN_W / 2;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int OUT_MAX    = 32767;

    typedef struct packed {
        logic full;
        logic empty;
    } rmq_fifo_stat_t;

endpackage

`default_nettype wire

// ===== rtl/rmq_front.sv =====
// Front end: takes a basis beat, picks the branch and forms the raw quaternion.
`default_nettype none

module rmq_front
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = 14,
    parameter int QW        = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2,
    parameter int MW        = QW - 1,
    parameter int EW        = 4 * MW + 5
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire logic [IN_W-1:0] s_tdata,
    input  wire logic            fifo_full,
    output logic                 push,
    output logic [EW-1:0]        entry
);

    localparam logic signed [QW-1:0] ONE = QW'(1) << FRAC_BITS;

    logic signed [FIELD_W-1:0] rx, ry, rz, ux, uy, uz, fx, fy, fz;
    logic signed [QW-1:0]      erx, ery, erz, eux, euy, euz, efx, efy, efz;
    logic signed [QW-1:0]      tr, q0, q1, q2, q3, dg;
    logic [MW-1:0]             m0, m1, m2, m3;
    logic                      use_diag, degen;
    logic                      f_valid_reg, f_valid_next;
    logic [EW-1:0]             f_entry_reg;
    logic                      accept;

    assign rx = s_tdata[0*FIELD_W +: FIELD_W];
    assign ry = s_tdata[1*FIELD_W +: FIELD_W];
    assign rz = s_tdata[2*FIELD_W +: FIELD_W];
    assign ux = s_tdata[3*FIELD_W +: FIELD_W];
    assign uy = s_tdata[4*FIELD_W +: FIELD_W];
    assign uz = s_tdata[5*FIELD_W +: FIELD_W];
    assign fx = s_tdata[6*FIELD_W +: FIELD_W];
    assign fy = s_tdata[7*FIELD_W +: FIELD_W];
    assign fz = s_tdata[8*FIELD_W +: FIELD_W];

    assign erx = {{(QW-FIELD_W){rx[FIELD_W-1]}}, rx};
    assign ery = {{(QW-FIELD_W){ry[FIELD_W-1]}}, ry};
    assign erz = {{(QW-FIELD_W){rz[FIELD_W-1]}}, rz};
    assign eux = {{(QW-FIELD_W){ux[FIELD_W-1]}}, ux};
    assign euy = {{(QW-FIELD_W){uy[FIELD_W-1]}}, uy};
    assign euz = {{(QW-FIELD_W){uz[FIELD_W-1]}}, uz};
    assign efx = {{(QW-FIELD_W){fx[FIELD_W-1]}}, fx};
    assign efy = {{(QW-FIELD_W){fy[FIELD_W-1]}}, fy};
    assign efz = {{(QW-FIELD_W){fz[FIELD_W-1]}}, fz};

    assign tr = erx + euy + efz;

    // q0..q3 = x, y, z, w; dg is the diagonal term of the chosen branch
    always_comb
    begin
        use_diag = 1'b1;
        priority if (!tr[QW-1] && (tr != '0))
        begin
            use_diag = 1'b0;
            q3 = tr + ONE;
            q0 = euz - efy;
            q1 = efx - erz;
            q2 = ery - eux;
            dg = q3;
        end
        else if ((rx > uy) && (rx > fz))
        begin
            q0 = ONE + erx - euy - efz;
            q3 = euz - efy;
            q1 = eux + ery;
            q2 = efx + erz;
            dg = q0;
        end
        else if (uy > fz)
        begin
            q1 = ONE + euy - erx - efz;
            q3 = efx - erz;
            q0 = eux + ery;
            q2 = efy + euz;
            dg = q1;
        end
        else
        begin
            q2 = ONE + efz - erx - euy;
            q3 = ery - eux;
            q0 = efx + erz;
            q1 = euz + efy;
            dg = q2;
        end
    end

    assign m0 = q0[QW-1] ? MW'(-q0) : MW'(q0);
    assign m1 = q1[QW-1] ? MW'(-q1) : MW'(q1);
    assign m2 = q2[QW-1] ? MW'(-q2) : MW'(q2);
    assign m3 = q3[QW-1] ? MW'(-q3) : MW'(q3);

    assign degen = (use_diag && (dg[QW-1] || (dg == '0)))
                 || ((m0 | m1 | m2 | m3) == '0);

    assign s_tready = !f_valid_reg || !fifo_full;
    assign accept   = s_tvalid && s_tready;
    assign push     = f_valid_reg && !fifo_full;
    assign entry    = f_entry_reg;

    always_comb
    begin
        f_valid_next = f_valid_reg;
        priority if (accept)
            f_valid_next = 1'b1;
        else if (push)
            f_valid_next = 1'b0;
        else
            f_valid_next = f_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_valid_reg <= 1'b0;
        else
            f_valid_reg <= f_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            f_entry_reg <= {degen, q3[QW-1], q2[QW-1], q1[QW-1], q0[QW-1], m3, m2, m1, m0};
    end

endmodule

`default_nettype wire

// ===== rtl/rmq_fifo.sv =====
// Short queue between front end and back end.
`default_nettype none

module rmq_fifo
    import rmq_pkg::*;
#(
    parameter int W = 8
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire logic [W-1:0] wdata,
    input  wire logic         pop,
    output logic [W-1:0]      rdata,
    output rmq_fifo_stat_t    stat
);

    logic [W-1:0]         mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]     count_reg, count_next;

    assign rdata      = mem_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign stat.empty = (count_reg == '0);

    always_comb
    begin
        count_next = count_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !stat.full) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !stat.empty) else $error("queue underflow");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (FIFO_AW+1)'(FIFO_DEPTH)) else $error("queue count out of range");

endmodule

`default_nettype wire

// ===== rtl/rmq_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
`default_nettype none

module rmq_sqrt
    import rmq_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic [SQ_IN_W-1:0] x,
    output logic [ROOT_W-1:0]       root
);

    localparam int RW = ROOT_W + 3;

    typedef struct packed {
        logic [RW-1:0]      rem;
        logic [ROOT_W-1:0]  root;
        logic [SQ_IN_W-1:0] xs;
    } sq_t;

    sq_t st_reg [ROOT_W];
    sq_t init;

    function automatic sq_t sq_step(sq_t p);
        sq_t           r;
        logic [RW-1:0] rn;
        logic [RW-1:0] trial;
        rn    = {p.rem[RW-3:0], p.xs[SQ_IN_W-1 -: 2]};
        trial = RW'({p.root, 2'b01});
        r.xs  = p.xs << 2;
        if (rn >= trial)
        begin
            r.rem  = rn - trial;
            r.root = {p.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            r.rem  = rn;
            r.root = {p.root[ROOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

    assign init = '{rem: '0, root: '0, xs: x};
    assign root = st_reg[ROOT_W-1].root;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0] <= sq_step(init);
            for (int k = 1; k < ROOT_W; k++)
                st_reg[k] <= sq_step(st_reg[k-1]);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rmq_div.sv =====
// Pipelined rounding divider for one quaternion lane, one quotient bit per stage.
`default_nettype none

module rmq_div
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = 14
) (
    input  wire logic                clk,
    input  wire logic                en,
    input  wire logic [NORM_TOP-1:0] num,
    input  wire logic [ROOT_W-1:0]   den,
    output logic [FRAC_BITS:0]       quo
);

    localparam int QB  = FRAC_BITS + 1;
    localparam int NW  = NORM_TOP + FRAC_BITS + SQRT_EXTRA + 1;
    localparam int RMW = ROOT_W + 1;

    typedef struct packed {
        logic [RMW-1:0]    rem;
        logic [QB-1:0]     low;
        logic [QB-1:0]     quo;
        logic [ROOT_W-1:0] den;
    } dv_t;

    dv_t           st_reg [QB];
    dv_t           init;
    logic [NW-1:0] n_full;

    function automatic dv_t dv_step(dv_t p);
        dv_t            r;
        logic [RMW-1:0] r2;
        r2    = {p.rem[RMW-2:0], p.low[QB-1]};
        r.low = p.low << 1;
        r.den = p.den;
        if (r2 >= {1'b0, p.den})
        begin
            r.rem = r2 - {1'b0, p.den};
            r.quo = {p.quo[QB-2:0], 1'b1};
        end
        else
        begin
            r.rem = r2;
            r.quo = {p.quo[QB-2:0], 1'b0};
        end
        return r;
    endfunction

    // numerator carries the half-divisor for round to nearest
    assign n_full = NW'({num, {(FRAC_BITS+SQRT_EXTRA){1'b0}}}) + NW'(den[ROOT_W-1:1]);
    assign init   = '{rem: RMW'(n_full[NW-1:QB]), low: n_full[QB-1:0], quo: '0, den: den};
    assign quo    = st_reg[QB-1].quo;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0] <= dv_step(init);
            for (int k = 1; k < QB; k++)
                st_reg[k] <= dv_step(st_reg[k-1]);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rmq_back.sv =====
// Back end: normalize, sum of squares, square root, four divides, output register.
`default_nettype none

module rmq_back
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = 14,
    parameter int MW        = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 1,
    parameter int EW        = 4 * MW + 5
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          fifo_empty,
    output logic               pop,
    input  wire logic [EW-1:0] entry,
    input  wire logic          m_tready,
    output logic               m_tvalid,
    output logic [OUT_W-1:0]   m_tdata,
    output logic               m_tuser
);

    localparam int PW = $clog2(MW);
    localparam int SW = MW + NORM_TOP;
    localparam int SV = 4 * NORM_TOP + 5;
    localparam int QB = FRAC_BITS + 1;
    localparam logic [QB-1:0] LIM = (FRAC_BITS >= 15) ? QB'(OUT_MAX) : (QB'(1) << FRAC_BITS);

    logic                adv;
    logic [MW-1:0]       em [4];
    logic [MW-1:0]       mx01, mx23;

    logic                a_valid_reg;
    logic [MW-1:0]       a_mag_reg [4];
    logic [MW-1:0]       a_max_reg;
    logic [4:0]          a_side_reg;

    logic                b_valid_reg;
    logic [MW-1:0]       b_mag_reg [4];
    logic [PW-1:0]       b_pos_reg, pos;
    logic [4:0]          b_side_reg;

    logic [NORM_TOP-1:0] sh [4];
    logic [SW-1:0]       wide [4];

    logic                c_valid_reg, d_valid_reg, e_valid_reg, f_valid_reg;
    logic [SV-1:0]       c_sv_reg, d_sv_reg, e_sv_reg, f_sv_reg;
    logic [SQ_W-1:0]     d_sq_reg [4];
    logic [SQ_W:0]       e_pair_reg [2];
    logic [SUM_W-1:0]    f_sum_reg;

    logic [SV-1:0]       sd_reg [ROOT_W];
    logic                sv_valid_reg [ROOT_W];
    logic [4:0]          dd_reg [QB];
    logic                dv_valid_reg [QB];

    logic [ROOT_W-1:0]   root;
    logic [FRAC_BITS:0]  quo [4];
    logic [FIELD_W-1:0]  lane [4];

    logic                o_valid_reg;
    logic [OUT_W-1:0]    o_data_reg;
    logic                o_degen_reg;

    // whole back end moves together; output register is the skid point
    assign adv = !o_valid_reg || m_tready;
    assign pop = adv && !fifo_empty;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
            em[k] = entry[k*MW +: MW];
    end

    assign mx01 = (em[0] > em[1]) ? em[0] : em[1];
    assign mx23 = (em[2] > em[3]) ? em[2] : em[3];

    always_comb
    begin
        pos = '0;
        for (int i = 0; i < MW; i++)
            if (a_max_reg[i])
                pos = PW'(i);
    end

    // bring the largest magnitude into [2^23, 2^24); right shifts truncate
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            wide[k] = SW'(b_mag_reg[k]);
            if (b_pos_reg >= PW'(NORM_TOP-1))
                wide[k] = wide[k] >> (b_pos_reg - PW'(NORM_TOP-1));
            else
                wide[k] = wide[k] << (PW'(NORM_TOP-1) - b_pos_reg);
            sh[k] = wide[k][NORM_TOP-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            for (int k = 0; k < ROOT_W; k++)
                sv_valid_reg[k] <= 1'b0;
            for (int k = 0; k < QB; k++)
                dv_valid_reg[k] <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= pop;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
            f_valid_reg <= e_valid_reg;
            sv_valid_reg[0] <= f_valid_reg;
            for (int k = 1; k < ROOT_W; k++)
                sv_valid_reg[k] <= sv_valid_reg[k-1];
            dv_valid_reg[0] <= sv_valid_reg[ROOT_W-1];
            for (int k = 1; k < QB; k++)
                dv_valid_reg[k] <= dv_valid_reg[k-1];
            o_valid_reg <= dv_valid_reg[QB-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 4; k++)
                a_mag_reg[k] <= em[k];
            a_max_reg  <= (mx01 > mx23) ? mx01 : mx23;
            a_side_reg <= entry[4*MW +: 5];

            b_mag_reg  <= a_mag_reg;
            b_pos_reg  <= pos;
            b_side_reg <= a_side_reg;

            c_sv_reg <= {b_side_reg, sh[3], sh[2], sh[1], sh[0]};

            d_sv_reg <= c_sv_reg;
            for (int k = 0; k < 4; k++)
                d_sq_reg[k] <= c_sv_reg[k*NORM_TOP +: NORM_TOP]
                             * c_sv_reg[k*NORM_TOP +: NORM_TOP];

            e_sv_reg      <= d_sv_reg;
            e_pair_reg[0] <= (SQ_W+1)'(d_sq_reg[0]) + (SQ_W+1)'(d_sq_reg[1]);
            e_pair_reg[1] <= (SQ_W+1)'(d_sq_reg[2]) + (SQ_W+1)'(d_sq_reg[3]);

            f_sv_reg  <= e_sv_reg;
            f_sum_reg <= SUM_W'(e_pair_reg[0]) + SUM_W'(e_pair_reg[1]);

            sd_reg[0] <= f_sv_reg;
            for (int k = 1; k < ROOT_W; k++)
                sd_reg[k] <= sd_reg[k-1];

            dd_reg[0] <= sd_reg[ROOT_W-1][4*NORM_TOP +: 5];
            for (int k = 1; k < QB; k++)
                dd_reg[k] <= dd_reg[k-1];

            o_data_reg  <= {lane[3], lane[2], lane[1], lane[0]};
            o_degen_reg <= dd_reg[QB-1][4];
        end
    end

    rmq_sqrt u_sqrt (
        .clk  (clk),
        .en   (adv),
        .x    ({f_sum_reg, {(2*SQRT_EXTRA){1'b0}}}),
        .root (root)
    );

    for (genvar g = 0; g < 4; g++)
    begin : g_lane
        logic [QB-1:0]      v;
        logic [FIELD_W-1:0] v16;

        rmq_div #(.FRAC_BITS(FRAC_BITS)) u_div (
            .clk (clk),
            .en  (adv),
            .num (sd_reg[ROOT_W-1][g*NORM_TOP +: NORM_TOP]),
            .den (root),
            .quo (quo[g])
        );

        assign v   = (quo[g] > LIM) ? LIM : quo[g];
        assign v16 = FIELD_W'(v);
        assign lane[g] = dd_reg[QB-1][4] ? '0
                       : (dd_reg[QB-1][g] ? (FIELD_W'(0) - v16) : v16);
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = o_data_reg;
    assign m_tuser  = o_degen_reg;

endmodule

`default_nettype wire

// ===== rtl/rotation_matrix_to_quaternion.sv =====
// Top level: rotation basis in, normalized quaternion and degenerate flag out.
//
//  channel  dir  fields (low bit first)                             width
//  s_*      in   right_x right_y right_z up_x up_y up_z fwd_x ...  144
//  m_*      out  tdata: quat_x quat_y quat_z quat_w; tuser: degen  64 + 1
//
// One beat per cycle sustained in both directions while m_tready stays high.
// A beat passes the front register, queue, six normalize/square/sum stages,
// 31 square-root stages, then FRAC_BITS+1 divider stages per lane and the
// output register. The root and divider pipelines are fully staged, one bit
// per stage.
// Reset clears only valid and queue state; no clearing pass is needed.
// A stalled output freezes the back end; the queue then absorbs up to four
// beats plus the front register before s_tready drops.
`default_nettype none

module rotation_matrix_to_quaternion
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = 14
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    // right_x, right_y, right_z, up_x, up_y, up_z, fwd_x, fwd_y, fwd_z
    input  wire logic [IN_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    // quat_x, quat_y, quat_z, quat_w
    output logic [OUT_W-1:0]      m_tdata,
    // degenerate
    output logic                  m_tuser
);

    localparam int QW = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
    localparam int MW = QW - 1;
    localparam int EW = 4 * MW + 5;

    logic           push, pop;
    logic [EW-1:0]  f_entry, q_entry;
    rmq_fifo_stat_t q_stat;

    rmq_front #(.FRAC_BITS(FRAC_BITS), .QW(QW), .MW(MW), .EW(EW)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .fifo_full (q_stat.full),
        .push      (push),
        .entry     (f_entry)
    );

    rmq_fifo #(.W(EW)) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (f_entry),
        .pop   (pop),
        .rdata (q_entry),
        .stat  (q_stat)
    );

    rmq_back #(.FRAC_BITS(FRAC_BITS), .MW(MW), .EW(EW)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .fifo_empty (q_stat.empty),
        .pop        (pop),
        .entry      (q_entry),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == '0)) else $error("degenerate beat not zero");

endmodule

`default_nettype wire

// ===== bench/tb_rotation_matrix_to_quaternion.sv =====
// Testbench for the rotation-matrix-to-quaternion converter: stream stimulus and scoreboard.
`default_nettype none

// Scoreboard: holds predicted quaternions in arrival order and checks results.
class quat_scoreboard;
    typedef struct packed {
        logic [15:0] qx;
        logic [15:0] qy;
        logic [15:0] qz;
        logic [15:0] qw;
        logic        degen;
    } quat_t;

    quat_t pending[$];
    int    errors;
    int    checked;
    int    degen_seen;

    function new();
        errors     = 0;
        checked    = 0;
        degen_seen = 0;
    endfunction

    // Integer square root, floor.
    static function logic [63:0] root_floor(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Predict the quaternion for one basis beat.
    static function quat_t convert(logic [143:0] beat, int frac);
        longint      e[9];
        longint      q[4];
        longint      t;
        longint      one;
        logic [63:0] mag[4];
        bit          neg[4];
        logic [63:0] a;
        logic [63:0] s;
        logic [63:0] m;
        logic [63:0] lim;
        logic [63:0] v;
        logic [15:0] r[4];
        bit          dg;
        quat_t       res;
        for (int i = 0; i < 9; i++) e[i] = longint'($signed(beat[16*i +: 16]));
        one = longint'(1) << frac;
        t   = e[0] + e[4] + e[8];
        dg  = 0;
        if (t > 0)
        begin
            q[3] = t + one; q[0] = e[5] - e[7]; q[1] = e[6] - e[2]; q[2] = e[1] - e[3];
        end
        else if (e[0] > e[4] && e[0] > e[8])
        begin
            q[0] = one + e[0] - e[4] - e[8];
            q[3] = e[5] - e[7]; q[1] = e[3] + e[1]; q[2] = e[6] + e[2];
            dg = q[0] <= 0;
        end
        else if (e[4] > e[8])
        begin
            q[1] = one + e[4] - e[0] - e[8];
            q[3] = e[6] - e[2]; q[0] = e[3] + e[1]; q[2] = e[7] + e[5];
            dg = q[1] <= 0;
        end
        else
        begin
            q[2] = one + e[8] - e[0] - e[4];
            q[3] = e[1] - e[3]; q[0] = e[6] + e[2]; q[1] = e[5] + e[7];
            dg = q[2] <= 0;
        end
        a = 0;
        for (int i = 0; i < 4; i++)
        begin
            neg[i] = q[i] < 0;
            mag[i] = neg[i] ? -q[i] : q[i];
            if (mag[i] > a) a = mag[i];
        end
        if (a == 0) dg = 1;
        if (dg)
            return '{16'd0, 16'd0, 16'd0, 16'd0, 1'b1};
        // Bring the largest magnitude into [2^23, 2^24).
        while (a >= (64'd1 << 24))
        begin
            a = a >> 1;
            for (int i = 0; i < 4; i++) mag[i] = mag[i] >> 1;
        end
        while (a < (64'd1 << 23))
        begin
            a = a << 1;
            for (int i = 0; i < 4; i++) mag[i] = mag[i] << 1;
        end
        s = 0;
        for (int i = 0; i < 4; i++) s = s + mag[i] * mag[i];
        m   = root_floor(s << 12);
        lim = 64'd1 << frac;
        if (lim > 32767) lim = 32767;
        for (int i = 0; i < 4; i++)
        begin
            v = ((mag[i] << (frac + 6)) + (m >> 1)) / m;
            if (v > lim) v = lim;
            if (neg[i]) v = -v;
            r[i] = v[15:0];
        end
        res = '{r[0], r[1], r[2], r[3], 1'b0};
        return res;
    endfunction

    function void note_basis(logic [143:0] beat, int frac);
        pending.push_back(convert(beat, frac));
    endfunction

    function void check_result(logic [63:0] data, logic user);
        quat_t exp_q;
        quat_t act_q;
        act_q = '{data[15:0], data[31:16], data[47:32], data[63:48], user};
        if (pending.size() == 0)
        begin
            $display("%0t: unexpected result %h", $time, act_q);
            errors++;
            return;
        end
        exp_q = pending.pop_front();
        checked++;
        if (act_q.degen) degen_seen++;
        if (act_q.qx !== exp_q.qx)
        begin
            $display("%0t: quat_x expected %h actual %h", $time, exp_q.qx, act_q.qx);
            errors++;
        end
        if (act_q.qy !== exp_q.qy)
        begin
            $display("%0t: quat_y expected %h actual %h", $time, exp_q.qy, act_q.qy);
            errors++;
        end
        if (act_q.qz !== exp_q.qz)
        begin
            $display("%0t: quat_z expected %h actual %h", $time, exp_q.qz, act_q.qz);
            errors++;
        end
        if (act_q.qw !== exp_q.qw)
        begin
            $display("%0t: quat_w expected %h actual %h", $time, exp_q.qw, act_q.qw);
            errors++;
        end
        if (act_q.degen !== exp_q.degen)
        begin
            $display("%0t: degenerate expected %b actual %b", $time, exp_q.degen,
                     act_q.degen);
            errors++;
        end
    endfunction
endclass

module tb_rotation_matrix_to_quaternion;
    timeunit 1ns;
    timeprecision 1ps;
    import rmq_pkg::*;

    localparam int FRAC       = 14;
    localparam int ONE        = 1 << FRAC;
    localparam int RAND_BEATS = 1130;
    localparam int LATENCY    = 40 + FRAC;
    localparam int CYCLE_CAP  = 400000;

    logic             clk = 0;
    logic             rst_n = 0;
    logic             s_tvalid = 0;
    logic             s_tready;
    // right_x, right_y, right_z, up_x, up_y, up_z, fwd_x, fwd_y, fwd_z
    logic [IN_W-1:0]  s_tdata = '0;
    logic             m_tvalid;
    logic             m_tready = 0;
    // quat_x, quat_y, quat_z, quat_w
    logic [OUT_W-1:0] m_tdata;
    // degenerate
    logic             m_tuser;

    quat_scoreboard board = new();
    int  cycles = 0;
    int  sent = 0;

    rotation_matrix_to_quaternion #(.FRAC_BITS(FRAC)) DUT (
        .clk, .rst_n, .s_tvalid, .s_tready, .s_tdata,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser
    );

    always #5 clk = ~clk;

    // Mostly short gaps, now and then a long one, and stretches with none.
    function automatic int gap_len(bit calm);
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Output monitor: sample at rising edge, checks every accepted result.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && m_tvalid && m_tready)
            board.check_result(m_tdata, m_tuser);
        if (cycles > CYCLE_CAP)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_rotation_matrix_to_quaternion: errors");
            $finish;
        end
    end

    // Receiver backpressure: random stalls driven at the falling edge.
    initial
    begin
        int g;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            m_tready <= 1'b1;
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                g = gap_len(((cycles / 2000) % 3) == 1);
                if (g > 0)
                begin
                    @(negedge clk);
                    m_tready <= 1'b0;
                    repeat (g - 1) @(negedge clk);
                end
            end
        end
    end

    // Send one basis beat after an optional gap; holds tvalid until the handshake.
    task automatic send_basis(logic [IN_W-1:0] beat, bit calm);
        int g;
        g = gap_len(calm);
        if (g > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= beat;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        board.note_basis(beat, FRAC);
        sent++;
        @(negedge clk);
    endtask

    function automatic logic [IN_W-1:0] pack9(int v[9]);
        logic [IN_W-1:0] b;
        for (int i = 0; i < 9; i++) b[16*i +: 16] = 16'(v[i]);
        return b;
    endfunction

    // Near-rotation: signed permutation of the axes plus small noise.
    function automatic logic [IN_W-1:0] near_rotation();
        int v[9];
        int perm;
        perm = $urandom_range(0, 5);
        for (int i = 0; i < 9; i++) v[i] = $signed($urandom_range(0, 2047)) - 1024;
        for (int c = 0; c < 3; c++)
        begin
            int row;
            row = (c + perm) % 3;
            if (perm >= 3) row = (3 - c + perm) % 3;
            v[3*c + row] += ($urandom_range(0, 1) ? ONE : -ONE);
        end
        return pack9(v);
    endfunction

    initial
    begin
        int v[9];
        logic [IN_W-1:0] b;
        int r;
        repeat (6) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // Directed: identity, the three diagonal branches, ties, extremes.
        v = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};            send_basis(pack9(v), 1);
        v = '{ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE};          send_basis(pack9(v), 1);
        v = '{-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE};          send_basis(pack9(v), 1);
        v = '{-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE};          send_basis(pack9(v), 1);
        v = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                  send_basis(pack9(v), 1);
        v = '{-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE};         send_basis(pack9(v), 1);
        // Diagonal branches with large negative diagonal entries.
        v = '{-100, 5, 6, 7, -20000, 8, 9, 10, -20000};    send_basis(pack9(v), 1);
        v = '{-30000, 1, 2, 3, -30000, 4, 5, 6, 20000};    send_basis(pack9(v), 1);
        v = '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768};
        send_basis(pack9(v), 0);
        v = '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767};
        send_basis(pack9(v), 0);
        v = '{32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767};
        send_basis(pack9(v), 0);
        v = '{-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768};
        send_basis(pack9(v), 0);
        // Trace exactly zero, and ties among diagonals.
        v = '{100, 3, 4, 5, -50, 6, 7, 8, -50};            send_basis(pack9(v), 0);
        v = '{-200, 1, 2, 3, -200, 4, 5, 6, -200};         send_basis(pack9(v), 0);
        v = '{-100, 1, 2, 3, 50, 4, 5, 6, 50};             send_basis(pack9(v), 0);
        v = '{1, 0, 0, 0, 0, 0, 0, 0, 0};                  send_basis(pack9(v), 0);
        // Zero trace, diagonal branch, off-diagonal fields large.
        v = '{-ONE, 32767, -32768, -32768, 0, 32767, 32767, -32768, ONE};
        send_basis(pack9(v), 0);

        // Random: mostly near-rotations, then raw bit patterns and small fields.
        for (int n = 0; n < RAND_BEATS; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 65)
                b = near_rotation();
            else if (r < 90)
                b = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
            else
            begin
                for (int i = 0; i < 9; i++) v[i] = $signed($urandom_range(0, 400)) - 200;
                b = pack9(v);
            end
            send_basis(b, ((n / 150) % 4) == 2);
        end
        s_tvalid <= 1'b0;

        while (board.pending.size() != 0) @(posedge clk);
        repeat (LATENCY + 20) @(posedge clk);

        $display("Sent %0d basis beats, %0d results checked (%0d degenerate).",
                 sent, board.checked, board.degen_seen);
        $display("Covered all four branches, zero and full-scale fields, random stalls.");
        if (board.errors == 0 && board.pending.size() == 0)
            $display("tb_rotation_matrix_to_quaternion: clean");
        else
            $display("tb_rotation_matrix_to_quaternion: errors");
        $finish;
    end
endmodule

`default_nettype wire

// ===== sim.f =====
rtl/rmq_pkg.sv
rtl/rmq_front.sv
rtl/rmq_fifo.sv
rtl/rmq_sqrt.sv
rtl/rmq_div.sv
rtl/rmq_back.sv
rtl/rotation_matrix_to_quaternion.sv
bench/tb_rotation_matrix_to_quaternion.sv
